FILE: hw/rtl/cdb_pkg.sv
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared types and constants of the constant-database lookup engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cdb_pkg;

  // default geometry
  localparam int unsigned IMAGE_BYTES_DEF   = 65536;
  localparam int unsigned MAX_KEY_BYTES_DEF = 64;

  // hash and image layout
  localparam logic [31:0] HASH_SEED    = 32'd5381;
  localparam int unsigned HEADER_BYTES = 2048;
  localparam logic [7:0]  HASH_MASK    = 8'hff;

  // width of unwrapped image offsets
  localparam int unsigned OFS_W = 36;

  // register byte addresses
  localparam logic [1:0] REG_IMAGE_SIZE = 2'd0;

  // request codes
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  // status codes
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_KEY_LONG = 2'd2;
  localparam logic [1:0] ST_BOUNDS   = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RA,
    S_RB,
    S_HDR,
    S_DIV,
    S_SLOT,
    S_ENT,
    S_REC,
    S_CMPA,
    S_CMPB,
    S_NEXT
  } cdb_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cdb_div.sv
// ----------------------------------------------------------------------------
// cdb_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cdb_div
  import cdb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [23:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      rem
);

  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [23:0] dvd_r, dvd_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [32:0] trial;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  // one shift and conditional subtract per cycle
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[23]};
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) rem_nxt = 32'(trial - {1'b0, dvs_r});
      else                        rem_nxt = trial[31:0];
      dvd_nxt = {dvd_r[22:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd23) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  // remainder stays below a non-zero divisor
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (done && dvs_r != 32'd0) |-> rem_r < dvs_r)
    else $error("remainder not below divisor");

  // done only after a run
  a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(run_r))
    else $error("done without run");

  // a run ends within its bit count
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> cnt_r <= 5'd23)
    else $error("divider count overrun");

endmodule

`default_nettype wire

FILE: hw/rtl/constant_db_hash_lookup_top.sv
// ----------------------------------------------------------------------------
// constant_db_hash_lookup_top
// Constant-database lookup engine: image byte store, key buffer, hash and
// probe sequencer.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | handshake
//  input    | in_req_type, in_image_addr, in_data_byte | start & !busy
//  result   | out_status, out_value_pos, out_value_len | out_valid, one cycle
//  config   | psel penable pwrite paddr pwdata prdata  | APB, pready high
//
//  image writes and key appends leave the sequencer idle; busy stays low
//  a lookup reads 8-byte words byte by byte from the byte store, takes the
//  slot remainder from cdb_div, compares the key byte by byte and has one
//  state for each header, slot, entry, record and next-slot decision
//  reset clears key state, image_size and the sequencer; stores stay undefined
//  busy is high while a lookup runs; the receiver cannot stall results
// ----------------------------------------------------------------------------
`default_nettype none

module constant_db_hash_lookup_top
  import cdb_pkg::*;
#(
  parameter int unsigned IMAGE_BYTES   = IMAGE_BYTES_DEF,
  parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [15:0] in_image_addr,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [15:0]      out_value_pos,
  output logic [16:0]      out_value_len,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW  = $clog2(IMAGE_BYTES);
  localparam int unsigned KCW = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [OFS_W-1:0] IMG_MAX = OFS_W'(IMAGE_BYTES);
  localparam logic [OFS_W-1:0] HDR_SZ  = OFS_W'(HEADER_BYTES);
  localparam logic [OFS_W-1:0] EIGHT   = OFS_W'(8);

  // stores
  logic [7:0] img_mem [IMAGE_BYTES];
  logic [7:0] key_mem [MAX_KEY_BYTES];
  logic [7:0] img_q, key_q;
  logic [AW-1:0] img_ra, img_wa;
  logic          img_we, key_we;

  cdb_state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [OFS_W-1:0] base_r, base_nxt;
  logic [2:0]       k_r, k_nxt;
  logic [63:0]      w_r, w_nxt;
  logic [31:0]      tpos_r, tpos_nxt, tlen_r, tlen_nxt;
  logic [31:0]      slot_r, slot_nxt, i_r, i_nxt;
  logic [31:0]      rp_r, rp_nxt, rk_r, rk_nxt, rv_r, rv_nxt;
  logic [KCW-1:0]   j_r, j_nxt;
  logic [31:0]      key_hash_r, key_hash_nxt;
  logic [KCW-1:0]   key_count_r, key_count_nxt;
  logic             key_ovf_r, key_ovf_nxt;
  logic [16:0]      image_size_r;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [15:0]      out_pos_r, out_pos_nxt;
  logic [16:0]      out_len_r, out_len_nxt;
  logic             div_go, div_done;
  logic [31:0]      div_rem;
  logic [OFS_W-1:0] size_w, ent_w, rec_end, body_end, cmp_a, slot_inc;
  logic             accept;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // clamped image size
  always_comb begin
    size_w = OFS_W'(image_size_r);
    if (size_w > IMG_MAX) size_w = IMG_MAX;
  end

  // offset arithmetic
  assign ent_w    = OFS_W'(tpos_r) + OFS_W'({slot_r, 3'b000});
  assign rec_end  = OFS_W'(w_r[63:32]) + EIGHT;
  assign body_end = OFS_W'(rp_r) + EIGHT + OFS_W'(w_r[31:0]) + OFS_W'(w_r[63:32]);
  assign cmp_a    = OFS_W'(rp_r) + EIGHT + OFS_W'(j_r);
  assign slot_inc = OFS_W'(slot_r) + OFS_W'(1);

  // configuration port
  assign pready = 1'b1;
  assign prdata = {15'd0, image_size_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= '0;
    end else if (psel && penable && pwrite && paddr == REG_IMAGE_SIZE) begin
      image_size_r <= pwdata[16:0];
    end
  end

  // image store, one write and one registered read port
  assign img_we = accept && in_req_type == REQ_WRITE;
  assign img_wa = AW'(OFS_W'(in_image_addr));
  assign img_ra = (state_r == S_CMPA) ? cmp_a[AW-1:0] : AW'(base_r + OFS_W'(k_r));
  always_ff @(posedge clk) begin
    if (img_we) img_mem[img_wa] <= in_data_byte;
    img_q <= img_mem[img_ra];
  end

  // key buffer
  assign key_we = accept && in_req_type == REQ_APPEND && key_count_r < KCW'(MAX_KEY_BYTES);
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_count_r[KIW-1:0]] <= in_data_byte;
    key_q <= key_mem[j_r[KIW-1:0]];
  end

  // slot remainder unit
  cdb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (key_hash_r[31:8]),
    .divisor  (tlen_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      key_hash_r  <= HASH_SEED;
      key_count_r <= '0;
      key_ovf_r   <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      key_hash_r  <= key_hash_nxt;
      key_count_r <= key_count_nxt;
      key_ovf_r   <= key_ovf_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    w_r          <= w_nxt;
    tpos_r       <= tpos_nxt;
    tlen_r       <= tlen_nxt;
    slot_r       <= slot_nxt;
    i_r          <= i_nxt;
    rp_r         <= rp_nxt;
    rk_r         <= rk_nxt;
    rv_r         <= rv_nxt;
    j_r          <= j_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_len_r    <= out_len_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    base_nxt       = base_r;
    k_nxt          = k_r;
    w_nxt          = w_r;
    tpos_nxt       = tpos_r;
    tlen_nxt       = tlen_r;
    slot_nxt       = slot_r;
    i_nxt          = i_r;
    rp_nxt         = rp_r;
    rk_nxt         = rk_r;
    rv_nxt         = rv_r;
    j_nxt          = j_r;
    key_hash_nxt   = key_hash_r;
    key_count_nxt  = key_count_r;
    key_ovf_nxt    = key_ovf_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_len_nxt    = out_len_r;
    div_go         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_APPEND: begin
              key_hash_nxt = ((key_hash_r << 5) + key_hash_r) ^ {24'd0, in_data_byte};
              if (key_count_r < KCW'(MAX_KEY_BYTES)) key_count_nxt = key_count_r + KCW'(1);
              else                                   key_ovf_nxt   = 1'b1;
            end
            REQ_LOOKUP: begin
              if (key_ovf_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_KEY_LONG;
              end else if (size_w < HDR_SZ) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_MISS;
              end else begin
                base_nxt  = OFS_W'({key_hash_r[7:0] & HASH_MASK, 3'b000});
                k_nxt     = '0;
                ret_nxt   = S_HDR;
                state_nxt = S_RA;
              end
            end
            default: ;
          endcase
        end
      end
      // 8-byte little-endian read, one byte per S_RA/S_RB pair
      S_RA: state_nxt = S_RB;
      S_RB: begin
        w_nxt[8*k_r +: 8] = img_q;
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd7) state_nxt = ret_r;
        else             state_nxt = S_RA;
      end
      S_HDR: begin
        tpos_nxt = w_r[31:0];
        tlen_nxt = w_r[63:32];
        if (w_r[63:32] == 32'd0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_MISS;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        div_go = (ret_r == S_HDR);
        ret_nxt = S_DIV;
        if (div_done) begin
          slot_nxt  = div_rem;
          i_nxt     = '0;
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        if (ent_w + EIGHT > size_w) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_BOUNDS;
          state_nxt      = S_IDLE;
        end else begin
          base_nxt  = ent_w;
          k_nxt     = '0;
          ret_nxt   = S_ENT;
          state_nxt = S_RA;
        end
      end
      S_ENT: begin
        rp_nxt = w_r[63:32];
        if (w_r[63:32] == 32'd0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_MISS;
          state_nxt      = S_IDLE;
        end else if (w_r[31:0] != key_hash_r) begin
          state_nxt = S_NEXT;
        end else if (rec_end > size_w) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_BOUNDS;
          state_nxt      = S_IDLE;
        end else begin
          base_nxt  = OFS_W'(w_r[63:32]);
          k_nxt     = '0;
          ret_nxt   = S_REC;
          state_nxt = S_RA;
        end
      end
      S_REC: begin
        rk_nxt = w_r[31:0];
        rv_nxt = w_r[63:32];
        j_nxt  = '0;
        if (w_r[31:0] != 32'(key_count_r)) begin
          state_nxt = S_NEXT;
        end else if (body_end > size_w) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_BOUNDS;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_CMPA;
        end
      end
      // key compare, one byte per S_CMPA/S_CMPB pair
      S_CMPA: begin
        if (j_r == key_count_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FOUND;
          out_pos_nxt    = 16'(OFS_W'(rp_r) + EIGHT + OFS_W'(rk_r));
          out_len_nxt    = rv_r[16:0];
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_CMPB;
        end
      end
      S_CMPB: begin
        if (img_q == key_q) begin
          j_nxt     = j_r + KCW'(1);
          state_nxt = S_CMPA;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        i_nxt = i_r + 32'd1;
        if (i_r + 32'd1 == tlen_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_MISS;
          state_nxt      = S_IDLE;
        end else begin
          slot_nxt  = (slot_inc == OFS_W'(tlen_r)) ? 32'd0 : slot_inc[31:0];
          state_nxt = S_SLOT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a result ends the key
    if (out_valid_nxt) begin
      state_nxt     = S_IDLE;
      key_hash_nxt  = HASH_SEED;
      key_count_nxt = '0;
      key_ovf_nxt   = 1'b0;
      if (out_status_nxt != ST_FOUND) begin
        out_pos_nxt = '0;
        out_len_nxt = '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_pos = out_pos_r;
  assign out_value_len = out_len_r;

  // a word leaves only with the sequencer back at rest
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE)
    else $error("result while sequencer busy");

  // a word leaves with the key state cleared
  a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (key_count_r == '0 && key_hash_r == HASH_SEED && !key_ovf_r))
    else $error("key state not cleared on result");

  // key count never passes the buffer depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= KCW'(MAX_KEY_BYTES))
    else $error("key count overrun");

  // a found word carries a full key compare
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FOUND) |-> $past(j_r == key_count_r))
    else $error("found without key compare");

endmodule

`default_nettype wire
